/* src/byte_budget_lru_directory_unit_assert.svh */
// Assertion macros shared by the directory RTL.
`ifndef BYTE_BUDGET_LRU_DIRECTORY_UNIT_ASSERT_SVH
`define BYTE_BUDGET_LRU_DIRECTORY_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BBLRU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BBLRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/bblru_pkg.sv */
// Types, constants and codes of the byte budget LRU directory.
`timescale 1ns / 1ps
`default_nettype none
package bblru_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int RANK_W     = IDX_W;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int KEY_PORT_W = 32;
   localparam int KEY_W      = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
   localparam int SIZE_W     = 32;
   localparam int BYTES_W    = 41;
   localparam int FRAC_W     = 9;
   localparam int TARGET_W   = BYTES_W + FRAC_W;
   localparam int CSR_ADDR_W = 2;

   localparam logic [BYTES_W-1:0] CAP_RESET  = BYTES_W'(1024 * 1024 * 1024);
   localparam logic [FRAC_W-1:0]  FRAC_ONE   = FRAC_W'(256);
   localparam logic [FRAC_W-1:0]  FRAC_RESET = FRAC_ONE;

   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_FRACTION = CSR_ADDR_W'(1);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISS    = 2'd1;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd2;

   localparam logic KIND_EVICT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOOKUP,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_CLEANUP
   } cmd_type;

   typedef enum logic [1:0] {
      REC_NONE,
      REC_TOUCH,
      REC_DROP,
      REC_PUSH
   } rec_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EVICT_CHECK,
      ST_EVICT_EMIT,
      ST_INSERT
   } state_type;

   typedef struct packed {
      rec_op_type       op;
      logic [IDX_W-1:0] idx;
   } rec_cmd_type;

   typedef struct packed {
      logic [ENTRIES-1:0] valid;
      logic [CNT_W-1:0]   count;
      logic [IDX_W-1:0]   oldest;
      logic [IDX_W-1:0]   free_idx;
   } rec_stat_type;

endpackage
`default_nettype wire

/* src/bblru_recency.sv */
// Valid bits, recency ranks and occupancy count of the directory entries.
`timescale 1ns / 1ps
`default_nettype none
module bblru_recency (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bblru_pkg::rec_cmd_type rec_cmd,
   output bblru_pkg::rec_stat_type     rec_stat
);

   logic [bblru_pkg::ENTRIES-1:0] valid_ff;
   logic [bblru_pkg::ENTRIES-1:0] valid_in;
   logic [bblru_pkg::RANK_W-1:0]  rank_ff [bblru_pkg::ENTRIES];
   logic [bblru_pkg::RANK_W-1:0]  rank_in [bblru_pkg::ENTRIES];
   logic [bblru_pkg::CNT_W-1:0]   count_ff;
   logic [bblru_pkg::CNT_W-1:0]   count_in;
   logic [bblru_pkg::RANK_W-1:0]  ref_rank;
   logic [bblru_pkg::CNT_W-1:0]   oldest_rank;
   logic [bblru_pkg::IDX_W-1:0]   oldest_idx;
   logic [bblru_pkg::IDX_W-1:0]   free_idx;

   assign ref_rank    = rank_ff[rec_cmd.idx];
   assign oldest_rank = count_ff - bblru_pkg::CNT_W'(1);

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      count_in = count_ff;
      unique case (rec_cmd.op)
         bblru_pkg::REC_TOUCH: begin
            for (int j = 0; j < bblru_pkg::ENTRIES; j++) begin
               if (valid_ff[j] && (j != int'(rec_cmd.idx)) && (rank_ff[j] < ref_rank)) begin
                  rank_in[j] = rank_ff[j] + bblru_pkg::RANK_W'(1);
               end
            end
            rank_in[rec_cmd.idx] = '0;
         end
         bblru_pkg::REC_DROP: begin
            for (int j = 0; j < bblru_pkg::ENTRIES; j++) begin
               if (valid_ff[j] && (j != int'(rec_cmd.idx)) && (rank_ff[j] > ref_rank)) begin
                  rank_in[j] = rank_ff[j] - bblru_pkg::RANK_W'(1);
               end
            end
            valid_in[rec_cmd.idx] = 1'b0;
            rank_in[rec_cmd.idx]  = '0;
            count_in              = count_ff - bblru_pkg::CNT_W'(1);
         end
         bblru_pkg::REC_PUSH: begin
            for (int j = 0; j < bblru_pkg::ENTRIES; j++) begin
               if (valid_ff[j]) begin
                  rank_in[j] = rank_ff[j] + bblru_pkg::RANK_W'(1);
               end
            end
            valid_in[rec_cmd.idx] = 1'b1;
            rank_in[rec_cmd.idx]  = '0;
            count_in              = count_ff + bblru_pkg::CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // The oldest entry carries the highest rank, which is one below the count.
   always_comb begin
      oldest_idx = '0;
      free_idx   = '0;
      for (int j = bblru_pkg::ENTRIES - 1; j >= 0; j--) begin
         if (valid_ff[j] && (bblru_pkg::CNT_W'(rank_ff[j]) == oldest_rank)) begin
            oldest_idx = bblru_pkg::IDX_W'(j);
         end
         if (!valid_ff[j]) begin
            free_idx = bblru_pkg::IDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int j = 0; j < bblru_pkg::ENTRIES; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         rank_ff  <= rank_in;
      end
   end

   assign rec_stat.valid    = valid_ff;
   assign rec_stat.count    = count_ff;
   assign rec_stat.oldest   = oldest_idx;
   assign rec_stat.free_idx = free_idx;

endmodule
`default_nettype wire

/* src/byte_budget_lru_directory_unit.sv */
// Top level of the byte budget LRU directory: sequencer, entry store and byte accounting.
//
//   Port group  Handshake              Carries
//   req_        req_valid / req_stall  cmd, key_id, item_size
//   rsp_        rsp_valid / rsp_stall  kind, out_key, out_size, status, total_bytes, last
//   csr_        csr_valid / csr_ready  register index and write data
//
// Lookup and remove search for the key by reading one entry per cycle from
// the single read port of the entry store, then decide and answer.
// Insert searches the same way, then evicts the oldest entries while the item does not fit
// the capacity and one more if the table is full; cleanup evicts while over its target.
// Reset clears all entries at once; no clearing pass is needed.
// A stalled result holds the sequencer only when it has a further item to show.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_budget_lru_directory_unit_assert.svh"
module byte_budget_lru_directory_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_cmd,
   input  wire logic [bblru_pkg::KEY_PORT_W-1:0]    req_key_id,
   input  wire logic [bblru_pkg::SIZE_W-1:0]        req_item_size,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_kind,
   output logic [bblru_pkg::KEY_PORT_W-1:0]         rsp_out_key,
   output logic [bblru_pkg::SIZE_W-1:0]             rsp_out_size,
   output logic [1:0]                               rsp_status,
   output logic [bblru_pkg::BYTES_W-1:0]            rsp_total_bytes,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bblru_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  wire logic [bblru_pkg::BYTES_W-1:0]       csr_wdata
);

   bblru_pkg::state_type             state_ff;
   bblru_pkg::state_type             state_in;
   logic [bblru_pkg::CNT_W-1:0]      scan_ff;
   logic [bblru_pkg::CNT_W-1:0]      scan_in;
   bblru_pkg::cmd_type               cmd_ff;
   logic [bblru_pkg::KEY_W-1:0]      key_ff;
   logic [bblru_pkg::SIZE_W-1:0]     size_ff;
   logic [bblru_pkg::BYTES_W-1:0]    cap_ff;
   logic [bblru_pkg::FRAC_W-1:0]     frac_ff;
   logic [bblru_pkg::FRAC_W-1:0]     frac_sat;
   logic [bblru_pkg::TARGET_W-1:0]   target_ff;
   logic [bblru_pkg::TARGET_W-1:0]   target_in;
   logic [bblru_pkg::BYTES_W-1:0]    held_ff;
   logic                             hit_ff;
   logic [bblru_pkg::IDX_W-1:0]      hit_idx_ff;
   logic [bblru_pkg::SIZE_W-1:0]     hit_size_ff;
   logic [bblru_pkg::IDX_W-1:0]      victim_ff;
   logic                             full_ff;
   logic                             full_in;
   logic                             victim_we;

   logic [bblru_pkg::KEY_W-1:0]      mem_key [bblru_pkg::ENTRIES];
   logic [bblru_pkg::SIZE_W-1:0]     mem_size [bblru_pkg::ENTRIES];
   logic [bblru_pkg::KEY_W-1:0]      mem_key_q;
   logic [bblru_pkg::SIZE_W-1:0]     mem_size_q;
   logic                             mem_we;
   logic                             rd_en;
   logic [bblru_pkg::IDX_W-1:0]      rd_addr;
   logic [bblru_pkg::IDX_W-1:0]      rd_idx_ff;
   logic                             rd_live_ff;
   logic                             key_match;

   logic [bblru_pkg::SIZE_W-1:0]     addsub_b;
   logic                             addsub_sub;
   logic [bblru_pkg::BYTES_W-1:0]    addsub_res;
   logic                             held_we;
   logic [bblru_pkg::BYTES_W:0]      ins_sum;
   logic [bblru_pkg::TARGET_W-1:0]   cmp_lhs;
   logic [bblru_pkg::TARGET_W-1:0]   cmp_rhs;
   logic                             over;

   bblru_pkg::rec_cmd_type           rec_cmd;
   bblru_pkg::rec_stat_type          rec_stat;

   logic                             rsp_valid_ff;
   logic                             rsp_kind_ff;
   logic                             rsp_kind_in;
   logic [bblru_pkg::KEY_PORT_W-1:0] rsp_key_ff;
   logic [bblru_pkg::KEY_PORT_W-1:0] rsp_key_in;
   logic [bblru_pkg::SIZE_W-1:0]     rsp_size_ff;
   logic [bblru_pkg::SIZE_W-1:0]     rsp_size_in;
   logic [1:0]                       rsp_status_ff;
   logic [1:0]                       rsp_status_in;
   logic [bblru_pkg::BYTES_W-1:0]    rsp_total_ff;
   logic [bblru_pkg::BYTES_W-1:0]    rsp_total_in;
   logic                             rsp_last_ff;
   logic                             rsp_last_in;
   logic                             load_rsp;
   logic                             out_free;

   bblru_recency u_recency (
      .clock    (clock),
      .reset    (reset),
      .rec_cmd  (rec_cmd),
      .rec_stat (rec_stat)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != bblru_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Byte accounting and budget comparison, shared by remove, insert and cleanup.
   assign addsub_res = addsub_sub ? (held_ff - bblru_pkg::BYTES_W'(addsub_b))
                                  : (held_ff + bblru_pkg::BYTES_W'(addsub_b));
   assign ins_sum    = (bblru_pkg::BYTES_W + 1)'(held_ff) + (bblru_pkg::BYTES_W + 1)'(size_ff);
   assign cmp_lhs    = (cmd_ff == bblru_pkg::CMD_INSERT) ? bblru_pkg::TARGET_W'(ins_sum)
                                                         : bblru_pkg::TARGET_W'({held_ff, 8'd0});
   assign cmp_rhs    = (cmd_ff == bblru_pkg::CMD_INSERT) ? bblru_pkg::TARGET_W'(cap_ff)
                                                         : target_ff;
   assign over       = (cmp_lhs > cmp_rhs);

   assign frac_sat  = (frac_ff > bblru_pkg::FRAC_ONE) ? bblru_pkg::FRAC_ONE : frac_ff;
   assign target_in = bblru_pkg::TARGET_W'(cap_ff) * bblru_pkg::TARGET_W'(frac_sat);

   assign key_match = rd_live_ff && rec_stat.valid[rd_idx_ff] && (mem_key_q == key_ff);

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      full_in       = full_ff;
      victim_we     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[bblru_pkg::IDX_W-1:0];
      mem_we        = 1'b0;
      rec_cmd.op    = bblru_pkg::REC_NONE;
      rec_cmd.idx   = hit_idx_ff;
      addsub_b      = hit_size_ff;
      addsub_sub    = 1'b1;
      held_we       = 1'b0;
      load_rsp      = 1'b0;
      rsp_kind_in   = bblru_pkg::KIND_STATUS;
      rsp_key_in    = bblru_pkg::KEY_PORT_W'(key_ff);
      rsp_size_in   = '0;
      rsp_status_in = bblru_pkg::STATUS_OK;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         bblru_pkg::ST_IDLE: begin
            full_in = 1'b0;
            scan_in = '0;
            if (req_valid) begin
               if (bblru_pkg::cmd_type'(req_cmd) == bblru_pkg::CMD_CLEANUP) begin
                  state_in = bblru_pkg::ST_EVICT_CHECK;
               end else begin
                  state_in = bblru_pkg::ST_SCAN;
               end
            end
         end
         bblru_pkg::ST_SCAN: begin
            if (scan_ff < bblru_pkg::CNT_W'(bblru_pkg::ENTRIES)) begin
               rd_en   = 1'b1;
               scan_in = scan_ff + bblru_pkg::CNT_W'(1);
            end else begin
               state_in = bblru_pkg::ST_DECIDE;
            end
         end
         bblru_pkg::ST_DECIDE: begin
            case (cmd_ff)
               bblru_pkg::CMD_LOOKUP: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = bblru_pkg::ST_IDLE;
                     if (hit_ff) begin
                        rec_cmd.op  = bblru_pkg::REC_TOUCH;
                        rsp_size_in = hit_size_ff;
                     end else begin
                        rsp_status_in = bblru_pkg::STATUS_MISS;
                     end
                  end
               end
               bblru_pkg::CMD_REMOVE: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = bblru_pkg::ST_IDLE;
                     if (hit_ff) begin
                        rec_cmd.op  = bblru_pkg::REC_DROP;
                        held_we     = 1'b1;
                        rsp_size_in = hit_size_ff;
                     end else begin
                        rsp_status_in = bblru_pkg::STATUS_MISS;
                     end
                  end
               end
               default: begin
                  // A key already present is replaced, so its old entry goes silently.
                  if (hit_ff) begin
                     rec_cmd.op = bblru_pkg::REC_DROP;
                     held_we    = 1'b1;
                  end
                  state_in = bblru_pkg::ST_EVICT_CHECK;
               end
            endcase
         end
         bblru_pkg::ST_EVICT_CHECK: begin
            if ((rec_stat.count != '0) && over) begin
               rd_en     = 1'b1;
               rd_addr   = rec_stat.oldest;
               victim_we = 1'b1;
               state_in  = bblru_pkg::ST_EVICT_EMIT;
            end else if (cmd_ff != bblru_pkg::CMD_INSERT) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  state_in = bblru_pkg::ST_IDLE;
               end
            end else if (over) begin
               if (out_free) begin
                  load_rsp      = 1'b1;
                  rsp_status_in = bblru_pkg::STATUS_NO_ROOM;
                  state_in      = bblru_pkg::ST_IDLE;
               end
            end else if (rec_stat.count == bblru_pkg::CNT_W'(bblru_pkg::ENTRIES)) begin
               rd_en     = 1'b1;
               rd_addr   = rec_stat.oldest;
               victim_we = 1'b1;
               full_in   = 1'b1;
               state_in  = bblru_pkg::ST_EVICT_EMIT;
            end else begin
               state_in = bblru_pkg::ST_INSERT;
            end
         end
         bblru_pkg::ST_EVICT_EMIT: begin
            addsub_b = mem_size_q;
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_kind_in   = bblru_pkg::KIND_EVICT;
               rsp_key_in    = bblru_pkg::KEY_PORT_W'(mem_key_q);
               rsp_size_in   = mem_size_q;
               rsp_last_in   = 1'b0;
               held_we       = 1'b1;
               rec_cmd.op    = bblru_pkg::REC_DROP;
               rec_cmd.idx   = victim_ff;
               full_in       = 1'b0;
               state_in      = full_ff ? bblru_pkg::ST_INSERT : bblru_pkg::ST_EVICT_CHECK;
            end
         end
         bblru_pkg::ST_INSERT: begin
            addsub_b    = size_ff;
            addsub_sub  = 1'b0;
            rec_cmd.idx = rec_stat.free_idx;
            if (out_free) begin
               load_rsp   = 1'b1;
               held_we    = 1'b1;
               mem_we     = 1'b1;
               rec_cmd.op = bblru_pkg::REC_PUSH;
               state_in   = bblru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bblru_pkg::ST_IDLE;
         end
      endcase
      rsp_total_in = held_we ? addsub_res : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bblru_pkg::ST_IDLE;
         scan_ff      <= '0;
         full_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rd_live_ff   <= 1'b0;
         held_ff      <= '0;
         cap_ff       <= bblru_pkg::CAP_RESET;
         frac_ff      <= bblru_pkg::FRAC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         full_ff    <= full_in;
         rd_live_ff <= rd_en && (state_ff == bblru_pkg::ST_SCAN);
         if (state_ff == bblru_pkg::ST_IDLE) begin
            hit_ff <= 1'b0;
         end else if ((state_ff == bblru_pkg::ST_SCAN) && key_match) begin
            hit_ff <= 1'b1;
         end
         if (held_we) begin
            held_ff <= addsub_res;
         end
         if (csr_valid) begin
            unique case (csr_index)
               bblru_pkg::CSR_CAPACITY: cap_ff <= csr_wdata;
               bblru_pkg::CSR_FRACTION: frac_ff <= csr_wdata[bblru_pkg::FRAC_W-1:0];
               default: begin
               end
            endcase
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff    <= bblru_pkg::cmd_type'(req_cmd);
         key_ff    <= req_key_id[bblru_pkg::KEY_W-1:0];
         size_ff   <= req_item_size;
         target_ff <= target_in;
      end
      if ((state_ff == bblru_pkg::ST_SCAN) && key_match) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_size_ff <= mem_size_q;
      end
      if (victim_we) begin
         victim_ff <= rec_stat.oldest;
      end
      if (load_rsp) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_size_ff   <= rsp_size_in;
         rsp_status_ff <= rsp_status_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_key[rec_stat.free_idx]  <= key_ff;
         mem_size[rec_stat.free_idx] <= size_ff;
      end
      if (rd_en) begin
         mem_key_q  <= mem_key[rd_addr];
         mem_size_q <= mem_size[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_size    = rsp_size_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_total_bytes = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

   `BBLRU_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != bblru_pkg::ST_IDLE, "accepted item did not start the sequencer")
   `BBLRU_ASSERT_SAME(a_count_matches_valid, clock, reset, 1'b1, $countones(rec_stat.valid) == int'(rec_stat.count), "entry count differs from valid bits")
   `BBLRU_ASSERT_SAME(a_oldest_is_valid, clock, reset, rec_stat.count != '0, rec_stat.valid[rec_stat.oldest], "oldest entry is not valid")
   `BBLRU_ASSERT_SAME(a_report_not_last, clock, reset, rsp_valid && (rsp_kind == bblru_pkg::KIND_EVICT), !rsp_last && (rsp_status == bblru_pkg::STATUS_OK), "eviction item marked as final")
   `BBLRU_ASSERT_NEXT(a_evict_drops_one, clock, reset, (state_ff == bblru_pkg::ST_EVICT_EMIT) && out_free, rec_stat.count + bblru_pkg::CNT_W'(1) == $past(rec_stat.count), "eviction did not free exactly one entry")

endmodule
`default_nettype wire
